@@ hw/rtl/sle_pkg.sv @@
// Shared types and constants for the serial line editor.
// Used by sle_front, sle_queue, sle_back and serial_line_editor_unit.
`default_nettype none

package sle_pkg;

    // Special characters of the line discipline
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_BELL  = 8'h07;

    // Result kinds on the output stream
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Configuration register byte offsets
    localparam logic [2:0] REG_MODAL = 3'd0;

    typedef enum logic [2:0] {
        OP_LINE,        // line complete
        OP_ERASE,       // echo BS, space, BS
        OP_STORE,       // store only (modal)
        OP_STORE_ECHO,  // store, then echo the character
        OP_BELL         // line full, echo bell
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;     // received character
        logic [7:0] pos;    // store index, or line length for OP_LINE
        logic       modal;  // routing of a finished line
    } t_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/serial_line_editor_unit.sv @@
// Top level of the serial line editor: APB register, front, queue and back.
// Depends on sle_pkg, sle_front, sle_queue and sle_back.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] rx_byte
//  m_axis    out        tdata: out_byte, char_index, line_length, to_modal;
//                       tuser: out_kind; tlast: last result of a byte
//  APB       in/out     byte address 0: modal_mode (bit 0)
//
// The front takes one byte per cycle while the four-entry command queue has
// room; bytes that give no result never enter the queue. The back emits one
// result beat per cycle unless stalled downstream; a byte gives one to three
// beats (three for an erase echo), counted by the back's step counter. Output
// beats sit in a register; input flows on while the command queue has room.
// Reset is synchronous: line position zero, modal_mode zero, queue empty.
`default_nettype none

module serial_line_editor_unit import sle_pkg::*; #(
    parameter int LINE_BYTES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // received bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] out_byte, [15:8] char_index,
                                             // [23:16] line_length, [24] to_modal
    output logic [1:0]       m_axis_tuser,   // [1:0] out_kind
    output logic             m_axis_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic r_modal;

    t_cmd w_push_cmd;
    t_cmd w_pop_cmd;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_avail;

    logic [7:0] w_byte;
    logic [7:0] w_index;
    logic [7:0] w_length;
    logic       w_to_modal;

    // Configuration: word-aligned decode, keep only bit 0
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modal <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_MODAL[2]) begin
            r_modal <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_MODAL[2]) ? {31'd0, r_modal} : 32'd0;

    // Front: classify and advance the line position
    sle_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_modal (r_modal),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // Queue: decouple byte intake from result emission
    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_cmd   (w_pop_cmd)
    );

    // Back: expand commands into result beats
    sle_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (w_avail),
        .i_cmd    (w_pop_cmd),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_kind   (m_axis_tuser),
        .o_byte   (w_byte),
        .o_index  (w_index),
        .o_length (w_length),
        .o_modal  (w_to_modal),
        .o_last   (m_axis_tlast)
    );

    // Pack result fields, lowest field first, pad to whole bytes
    assign m_axis_tdata = {7'd0, w_to_modal, w_length, w_index, w_byte};

endmodule

`default_nettype wire

@@ hw/rtl/sle_front.sv @@
// Front part: accepts received bytes, classifies them and tracks the line position.
// Depends on sle_pkg; feeds commands into sle_queue.
`default_nettype none

module sle_front import sle_pkg::*; #(
    parameter int LINE_BYTES = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_modal,
    input  wire logic       i_full,
    output logic            o_ready,
    output logic            o_push,
    output t_cmd            o_cmd
);

    // Longest line: LINE_BYTES-1, capped by the 8-bit position
    localparam int LIMIT = (LINE_BYTES - 1 > 255) ? 255 : (LINE_BYTES - 1);
    localparam logic [7:0] LIMIT_W = LIMIT[7:0];

    logic [7:0] r_pos;
    logic [7:0] n_pos;
    logic       w_accept;
    logic       w_has;
    t_cmd       w_cmd;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_pos     = r_pos;
        w_has     = 1'b0;
        w_cmd.op  = OP_LINE;
        w_cmd.ch  = i_byte;
        w_cmd.pos = r_pos;
        w_cmd.modal = i_modal;
        if (i_byte == CH_CR || i_byte == CH_LF) begin
            w_has = 1'b1;
            n_pos = 8'd0;
        end else if (i_byte == CH_BS || i_byte == CH_DEL) begin
            if (r_pos != 8'd0) begin
                n_pos    = r_pos - 8'd1;
                w_has    = !i_modal;
                w_cmd.op = OP_ERASE;
            end
        end else if (i_byte >= CH_SPACE && i_byte <= CH_TILDE) begin
            if (r_pos < LIMIT_W) begin
                n_pos    = r_pos + 8'd1;
                w_has    = 1'b1;
                w_cmd.op = i_modal ? OP_STORE : OP_STORE_ECHO;
            end else begin
                w_has    = !i_modal;
                w_cmd.op = OP_BELL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 8'd0;
        end else if (w_accept) begin
            r_pos <= n_pos;
        end
    end

    assign o_push = w_accept && w_has;
    assign o_cmd  = w_cmd;

endmodule

`default_nettype wire

@@ hw/rtl/sle_queue.sv @@
// Short command queue between the front and the back of the line editor.
// Depends on sle_pkg for the command type and depth.
`default_nettype none

module sle_queue import sle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_avail,
    output t_cmd      o_cmd
);

    localparam logic [QUEUE_PTR_W:0] DEPTH_W = QUEUE_DEPTH[QUEUE_PTR_W:0];

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == DEPTH_W);
    assign o_avail = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_avail |-> !i_pop) else $error("queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_W) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ hw/rtl/sle_back.sv @@
// Back part: expands queued commands into one to three result beats.
// Depends on sle_pkg; drives the registered output stream.
`default_nettype none

module sle_back import sle_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_avail,
    input  wire t_cmd       i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_byte,
    output logic [7:0]      o_index,
    output logic [7:0]      o_length,
    output logic            o_modal,
    output logic            o_last
);

    t_cmd       r_cmd;
    logic       r_busy;
    logic [1:0] r_step;

    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic [7:0] r_index;
    logic [7:0] r_length;
    logic       r_modal;
    logic       r_last;

    logic [1:0] w_kind;
    logic [7:0] w_byte;
    logic [7:0] w_index;
    logic [7:0] w_length;
    logic       w_modal;
    logic       w_last;
    logic       w_load;
    logic       w_fin;

    // Beat for the current command and step
    always_comb begin
        w_kind   = KIND_ECHO;
        w_byte   = 8'd0;
        w_index  = 8'd0;
        w_length = 8'd0;
        w_modal  = 1'b0;
        w_last   = 1'b1;
        unique case (r_cmd.op)
            OP_LINE: begin
                w_kind   = KIND_LINE;
                w_length = r_cmd.pos;
                w_modal  = r_cmd.modal;
            end
            OP_ERASE: begin
                w_byte = (r_step == 2'd1) ? CH_SPACE : CH_BS;
                w_last = (r_step == 2'd2);
            end
            OP_STORE: begin
                w_kind  = KIND_STORE;
                w_byte  = r_cmd.ch;
                w_index = r_cmd.pos;
            end
            OP_STORE_ECHO: begin
                w_byte = r_cmd.ch;
                w_last = (r_step == 2'd1);
                if (r_step == 2'd0) begin
                    w_kind  = KIND_STORE;
                    w_index = r_cmd.pos;
                end
            end
            OP_BELL: begin
                w_byte = CH_BELL;
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    assign w_load = r_busy && (!r_valid || i_ready);
    assign w_fin  = w_load && w_last;
    assign o_pop  = i_avail && (!r_busy || w_fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_fin) begin
                r_step <= 2'd0;
            end else if (w_load) begin
                r_step <= r_step + 2'd1;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_load) begin
            r_kind   <= w_kind;
            r_byte   <= w_byte;
            r_index  <= w_index;
            r_length <= w_length;
            r_modal  <= w_modal;
            r_last   <= w_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_byte   = r_byte;
    assign o_index  = r_index;
    assign o_length = r_length;
    assign o_modal  = r_modal;
    assign o_last   = r_last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 2'd3) else $error("step counter out of range");

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_step == 2'd0) else $error("step left over when idle");

    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == KIND_LINE) |-> r_last) else $error("line beat not last");

    a_store_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_cmd.op == OP_STORE_ECHO && r_step == 2'd0) |=> r_busy)
        else $error("echo after store lost");

endmodule

`default_nettype wire
